// ----- rtl/core/store_buffer_forwarding_macros.svh -----
// Assertion macros used by the store buffer datapath.
`ifndef STORE_BUFFER_FORWARDING_MACROS_SVH
`define STORE_BUFFER_FORWARDING_MACROS_SVH
`ifndef SYNTH
`define SBF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("store buffer assertion failed");
`define SBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("store buffer assertion failed");
`else
`define SBF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SBF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/sbf_pkg.sv -----
// Types and constants of the store buffer with load forwarding.
`default_nettype none
package sbf_pkg;

   localparam int ADDR_W  = 32;
   localparam int DATA_W  = 32;
   localparam int ROB_W   = 4;
   localparam int ENTRY_W = ADDR_W + DATA_W + ROB_W;
   localparam int REQ_W   = 72;   // addr, value, rob packed, padded to bytes
   localparam int RSP_W   = 104;  // result fields packed, padded to bytes

   localparam logic [ADDR_W-1:0] WORD_MASK = 32'hFFFF_FFFC;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP,
      ST_FLUSH,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_HEAD_RD,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;        // take the input word
      logic push;         // write tail entry, advance tail
      logic pop;          // read head entry, retire it if valid
      logic flush;        // clear valid marks and pointers
      logic head_read;    // read head entry for the report
      logic scan_read;    // read the entry under the scan index
      logic scan_step;    // move scan to the next older entry
      logic hit_capture;  // record forward data
      logic load_output;  // load the response register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type in_cmd;    // command on the input port
      logic    scan_match;
      logic    scan_last;
      logic    out_free;
   } ctl_status_type;

endpackage
`default_nettype wire

// ----- rtl/core/sbf_datapath.sv -----
// Store buffer datapath: entry memory, valid marks, pointers, scan and response.
`default_nettype none
`include "store_buffer_forwarding_macros.svh"
module sbf_datapath
   import sbf_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_cmd_type       ctl,
   output ctl_status_type         sts,
   input  wire logic [REQ_W-1:0]  req_tdata,
   input  wire logic [1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata
);

   localparam int PW = $clog2(DEPTH);
   localparam logic [PW:0]   DEPTH_W  = (PW+1)'(DEPTH);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      return (p == '0) ? LAST_IDX : p - 1'b1;
   endfunction

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [ADDR_W-1:0]  q_addr_ff;
   logic [DATA_W-1:0]  q_value_ff;
   logic [ROB_W-1:0]   q_rob_ff;

   logic [PW-1:0]      head_ff, head_in;
   logic [PW-1:0]      tail_ff, tail_in;
   logic               valid_ff [DEPTH];
   logic               valid_in [DEPTH];

   logic [PW-1:0]      scan_idx_ff, scan_idx_in;
   logic [PW-1:0]      scan_left_ff, scan_left_in;
   logic               scan_vld_ff, scan_vld_in;
   logic               slot_valid_ff, slot_valid_in;
   logic               hit_ff, hit_in;
   logic [DATA_W-1:0]  fwd_ff, fwd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [PW:0]        span;
   logic               rd_en;
   logic [PW-1:0]      rd_addr;
   logic [ADDR_W-1:0]  rd_entry_addr;
   logic [DATA_W-1:0]  rd_entry_data;
   logic [ROB_W-1:0]   rd_entry_rob;

   assign rd_entry_addr = rd_data_ff[ADDR_W-1:0];
   assign rd_entry_data = rd_data_ff[ADDR_W+DATA_W-1:ADDR_W];
   assign rd_entry_rob  = rd_data_ff[ENTRY_W-1:ADDR_W+DATA_W];

   // pointer and valid mark updates
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      valid_in = valid_ff;
      if (ctl.push) begin
         valid_in[tail_ff] = 1'b1;
         tail_in           = ptr_inc(tail_ff);
      end
      if (ctl.pop && valid_ff[head_ff]) begin
         valid_in[head_ff] = 1'b0;
         head_in           = ptr_inc(head_ff);
      end
      if (ctl.flush) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_in[i] = 1'b0;
         end
         head_in = '0;
         tail_in = '0;
      end
   end

   // scan runs from just below the tail down to the head, whole ring when equal
   assign span = {1'b0, tail_ff} + (DEPTH_W - 1'b1) - {1'b0, head_ff};

   always_comb begin
      scan_idx_in  = scan_idx_ff;
      scan_left_in = scan_left_ff;
      if (ctl.latch) begin
         scan_idx_in  = ptr_dec(tail_ff);
         scan_left_in = (span >= DEPTH_W) ? PW'(span - DEPTH_W) : span[PW-1:0];
      end else if (ctl.scan_step) begin
         scan_idx_in  = ptr_dec(scan_idx_ff);
         scan_left_in = scan_left_ff - 1'b1;
      end
   end

   assign rd_en   = ctl.pop | ctl.head_read | ctl.scan_read;
   assign rd_addr = ctl.scan_read ? scan_idx_ff : head_ff;

   always_comb begin
      scan_vld_in   = ctl.scan_read ? valid_ff[scan_idx_ff] : scan_vld_ff;
      slot_valid_in = slot_valid_ff;
      if (ctl.pop || ctl.head_read) begin
         slot_valid_in = valid_ff[head_ff];
      end else if (ctl.flush) begin
         slot_valid_in = 1'b0;
      end
      hit_in = hit_ff;
      fwd_in = fwd_ff;
      if (ctl.latch) begin
         hit_in = 1'b0;
         fwd_in = '0;
      end else if (ctl.hit_capture) begin
         hit_in = 1'b1;
         fwd_in = rd_entry_data;
      end
   end

   // response register; invalid slot reads as zero
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.load_output) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, fwd_ff, hit_ff,
                         slot_valid_ff ? rd_entry_rob  : {ROB_W{1'b0}},
                         slot_valid_ff ? rd_entry_data : {DATA_W{1'b0}},
                         slot_valid_ff ? rd_entry_addr : {ADDR_W{1'b0}},
                         slot_valid_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= {q_rob_ff, q_value_ff, q_addr_ff};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         q_addr_ff  <= req_tdata[ADDR_W-1:0];
         q_value_ff <= req_tdata[ADDR_W+DATA_W-1:ADDR_W];
         q_rob_ff   <= req_tdata[ENTRY_W-1:ADDR_W+DATA_W];
      end
      scan_idx_ff   <= scan_idx_in;
      scan_left_ff  <= scan_left_in;
      scan_vld_ff   <= scan_vld_in;
      slot_valid_ff <= slot_valid_in;
      hit_ff        <= hit_in;
      fwd_ff        <= fwd_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   assign sts.in_cmd     = cmd_type'(req_tuser);
   assign sts.scan_match = scan_vld_ff &&
                           ((rd_entry_addr & WORD_MASK) == (q_addr_ff & WORD_MASK));
   assign sts.scan_last  = (scan_left_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SBF_ASSERT_IMPL(a_load_when_free, clock, reset, ctl.load_output, !rsp_valid_ff || rsp_tready)
   `SBF_ASSERT_NEXT(a_flush_clears, clock, reset, ctl.flush, head_ff == '0 && tail_ff == '0)
   `SBF_ASSERT_NEXT(a_pop_advances, clock, reset, ctl.pop && valid_ff[head_ff], head_ff != $past(head_ff))

endmodule
`default_nettype wire

// ----- rtl/core/sbf_controller.sv -----
// Store buffer sequencer: steps each command through the datapath.
`default_nettype none
module sbf_controller
   import sbf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire ctl_status_type sts,
   output ctl_cmd_type         ctl
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (sts.in_cmd)
                  CMD_PUSH:  state_in = ST_PUSH;
                  CMD_POP:   state_in = ST_POP;
                  CMD_QUERY: state_in = ST_SCAN_RD;
                  default:   state_in = ST_FLUSH;
               endcase
            end
         end
         ST_PUSH:     state_in = ST_HEAD_RD;
         ST_POP:      state_in = ST_DONE;
         ST_FLUSH:    state_in = ST_DONE;
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (sts.scan_match || sts.scan_last) begin
               state_in = ST_HEAD_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_HEAD_RD:  state_in = ST_DONE;
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE:     ctl.latch       = accept;
         ST_PUSH:     ctl.push        = 1'b1;
         ST_POP:      ctl.pop         = 1'b1;
         ST_FLUSH:    ctl.flush       = 1'b1;
         ST_SCAN_RD:  ctl.scan_read   = 1'b1;
         ST_SCAN_CMP: begin
            ctl.hit_capture = sts.scan_match;
            ctl.scan_step   = !sts.scan_match && !sts.scan_last;
         end
         ST_HEAD_RD:  ctl.head_read   = 1'b1;
         ST_DONE:     ctl.load_output = sts.out_free;
         default:     ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/store_buffer_forwarding.sv -----
// Top level of the store buffer with load forwarding.
`default_nettype none
// Circular buffer of DEPTH pending stores with youngest-first load forwarding.
// Each input word carries a command in req_tuser: push writes the tail entry
// (overwriting the head when full), pop retires the head entry (ignored with
// slot_valid 0 when the head is empty), query searches from the entry below
// the tail down to the head for a valid store to the same word address and
// forwards its data, flush empties the buffer. Every response word reports
// the popped entry, or the head entry as it stands after the command.
// One command is worked at a time. A query examines from 1 to DEPTH entries,
// stopping at a hit or at the end of the range. The entry store has a single
// registered read port, so the query examines one entry per read/compare
// pair, and the head report takes one more read.
// The response register lets a finished word wait on rsp_tready; the next
// command is accepted meanwhile and stalls only at its own response. Valid
// marks are flip-flops cleared by reset, so no clearing pass is needed.
module store_buffer_forwarding
   import sbf_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // store_address[31:0], store_value[63:32], rob_index[67:64], zero pad
   input  wire logic [REQ_W-1:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // slot_valid[0], slot_address[32:1], slot_data[64:33], slot_rob_index[68:65],
   // hit[69], forward_data[101:70], zero pad
   output logic [RSP_W-1:0]      rsp_tdata
);

   ctl_cmd_type    ctl;
   ctl_status_type sts;

   sbf_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   sbf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
